@@ hdl/bsr_pkg.sv @@
// shared types and constants for the brush shape rasterizer
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;
  localparam int MAX_GRID_DEF  = 64;
  localparam int MAX_BRUSH_DEF = 15;

  localparam logic [3:0] OP_STAMP  = 4'd0;
  localparam logic [3:0] OP_ERASE  = 4'd1;
  localparam logic [3:0] OP_LINE   = 4'd2;
  localparam logic [3:0] OP_RECT   = 4'd3;
  localparam logic [3:0] OP_FRECT  = 4'd4;
  localparam logic [3:0] OP_CIRC   = 4'd5;
  localparam logic [3:0] OP_FCIRC  = 4'd6;
  localparam logic [3:0] OP_READ   = 4'd7;
  localparam logic [3:0] OP_CLEAR  = 4'd8;

  // config register byte addresses
  localparam logic [2:0] ADDR_GRID  = 3'd0;
  localparam logic [2:0] ADDR_BRUSH = 3'd4;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_STAMP_INIT, CMD_STAMP_STEP, CMD_SHAPE_STEP,
    CMD_CLEAR_STEP, CMD_READ_ADDR, CMD_READ_TAKE, CMD_CLEAR_INIT
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic point_ok;    // current plot point is inside the grid (and inside the circle for a filled circle)
    logic stamp_last;  // last pixel of the current brush square
    logic shape_last;  // no more points in current shape
    logic clear_last;  // last entry of clearing sweep
    logic is_shape;    // opcode walks a shape
    logic is_erase;
    logic is_stamp;
    logic is_read;
    logic is_clear;
  } status_t;
endpackage
`default_nettype wire

@@ hdl/brush_shape_rasterizer.sv @@
// top level: config registers, controller and datapath
// reads pass decode, address, wait and take states; draws test each plotted point, then stamp its brush pixels
// throughput: one command at a time; in_stall holds new commands until the controller is back in idle
// reset: synchronous; registers to grid 32 and brush 1, then a setup state and a clearing
// sweep over all MAX_GRID*MAX_GRID entries zero the store before the first command
`timescale 1ns / 1ps
`default_nettype none
module brush_shape_rasterizer
  import bsr_pkg::*;
#(
  parameter int MAX_GRID  = MAX_GRID_DEF,
  parameter int MAX_BRUSH = MAX_BRUSH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  opcode,
  input  wire logic [5:0]  start_x,
  input  wire logic [5:0]  start_y,
  input  wire logic [5:0]  end_x,
  input  wire logic [5:0]  end_y,
  input  wire logic [31:0] draw_color,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_color,
  output logic             in_grid
);
  logic [6:0] grid_size;
  logic [3:0] brush_size;
  status_t status;
  cmd_t cmd;

  assign pready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= 7'd32;
      brush_size <= 4'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_GRID) grid_size <= pwdata[6:0];
      else if (paddr == ADDR_BRUSH) brush_size <= pwdata[3:0];
    end
  end

  // config reads
  always_comb begin
    unique case (paddr)
      ADDR_GRID:  prdata = {25'd0, grid_size};
      ADDR_BRUSH: prdata = {28'd0, brush_size};
      default:    prdata = 32'd0;
    endcase
  end

  bsr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  bsr_datapath #(.MAX_GRID(MAX_GRID), .MAX_BRUSH(MAX_BRUSH)) u_dp (
    .clk(clk), .cmd(cmd), .opcode(opcode), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y), .draw_color(draw_color),
    .grid_size(grid_size), .brush_size(brush_size), .status(status),
    .read_color(read_color), .in_grid(in_grid)
  );
endmodule
`default_nettype wire

@@ hdl/bsr_ram.sv @@
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read first port: registered read returns the old word during a write
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ hdl/bsr_datapath.sv @@
// shape walkers, brush stamp counters and pixel store
`timescale 1ns / 1ps
`default_nettype none
module bsr_datapath
  import bsr_pkg::*;
#(
  parameter int MAX_GRID  = MAX_GRID_DEF,
  parameter int MAX_BRUSH = MAX_BRUSH_DEF
) (
  input  wire logic        clk,
  input  wire cmd_t        cmd,
  input  wire logic [3:0]  opcode,
  input  wire logic [5:0]  start_x,
  input  wire logic [5:0]  start_y,
  input  wire logic [5:0]  end_x,
  input  wire logic [5:0]  end_y,
  input  wire logic [31:0] draw_color,
  input  wire logic [6:0]  grid_size,
  input  wire logic [3:0]  brush_size,
  output status_t          status,
  output logic [31:0]      read_color,
  output logic             in_grid
);
  localparam int AW = $clog2(MAX_GRID);
  localparam int DEPTH = MAX_GRID * MAX_GRID;
  localparam int MW = $clog2(DEPTH);
  // signed coordinate width covers centre plus/minus radius and brush
  localparam int CW = ((AW > 6) ? AW : 6) + 3;

  logic [3:0]  op;
  logic [31:0] color;
  logic signed [CW-1:0] px, py;        // current plot point
  logic signed [CW-1:0] sxv, syv;      // stamp pixel
  logic signed [CW-1:0] xa, ya, xb, yb; // ordered/endpoints
  logic signed [CW-1:0] ccx, ccy;
  logic signed [CW+1:0] err;
  logic signed [CW-1:0] ldx, ldy;
  logic lsx, lsy;                      // line step directions negative
  logic signed [CW-1:0] cr, cu, cv;    // circle radius and walker
  logic [2:0] oct;                     // octant index
  logic [1:0] edge_sel;                // rect outline phase
  logic signed [CW-1:0] gsi;
  logic [4:0] hb;
  logic [MW-1:0] clr_addr;
  logic [MW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;
  logic ram_we;
  logic read_ok;

  // effective grid side and brush half-width
  always_comb begin
    if (9'(grid_size) > 9'(MAX_GRID)) gsi = CW'(MAX_GRID);
    else gsi = CW'(grid_size);
    if (5'(brush_size) > 5'(MAX_BRUSH)) hb = 5'(MAX_BRUSH / 2);
    else hb = 5'(brush_size >> 1);
  end

  function automatic logic ins(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic signed [CW-1:0] g);
    return x >= 0 && x < g && y >= 0 && y < g;
  endfunction

  // circle walker offsets mirrored into the current octant
  logic signed [CW-1:0] ox, oy;
  always_comb begin
    ox = '0; oy = '0;
    unique case (oct)
      3'd0: begin ox = cu;  oy = cv;  end
      3'd1: begin ox = cv;  oy = cu;  end
      3'd2: begin ox = -cv; oy = cu;  end
      3'd3: begin ox = -cu; oy = cv;  end
      3'd4: begin ox = -cu; oy = -cv; end
      3'd5: begin ox = -cv; oy = -cu; end
      3'd6: begin ox = cv;  oy = -cu; end
      default: begin ox = cu; oy = -cv; end
    endcase
  end

  logic signed [CW-1:0] ptx, pty;
  always_comb begin
    case (op)
      OP_LINE, OP_RECT, OP_FRECT: begin ptx = px; pty = py; end
      OP_CIRC: begin ptx = ccx + ox; pty = ccy + oy; end
      OP_FCIRC: begin ptx = ccx + cu; pty = ccy + cv; end
      default: begin ptx = xa; pty = ya; end
    endcase
  end

  // filled circle distance test, one product pair a point
  logic signed [2*CW-1:0] d2, r2;
  assign d2 = cu * cu + cv * cv;
  assign r2 = cr * cr;
  logic fc_in;
  assign fc_in = (op != OP_FCIRC) || (d2 <= r2);

  // midpoint circle step values
  logic signed [CW-1:0] nu, nv;
  logic signed [CW+1:0] nerr;
  always_comb begin
    nu = cu; nv = cv; nerr = err;
    if (nerr <= 0) begin
      nv = cv + 1;
      nerr = nerr + (CW+2)'(2 * nv + 1);
    end
    if (nerr > 0) begin
      nu = cu - 1;
      nerr = nerr - (CW+2)'(2 * nu + 1);
    end
  end

  // status
  logic shape_done;
  always_comb begin
    shape_done = 1'b0;
    case (op)
      OP_LINE: shape_done = (px == xb) && (py == yb);
      OP_RECT: shape_done = (edge_sel == 2'd3) && (py >= yb - 1) ||
                            (edge_sel == 2'd1 && px == xb && ya + 1 >= yb);
      OP_FRECT: shape_done = (px == xb) && (py == yb);
      OP_CIRC: shape_done = (oct == 3'd7) && (nu < nv);
      OP_FCIRC: shape_done = (cu == cr) && (cv == cr);
      default: shape_done = 1'b1;
    endcase
  end

  assign status.point_ok   = ins(ptx, pty, gsi) && fc_in;
  assign status.stamp_last = (sxv == ptx + CW'(hb)) && (syv == pty + CW'(hb));
  assign status.shape_last = shape_done;
  assign status.clear_last = &clr_addr;
  assign status.is_shape   = op == OP_LINE || op == OP_RECT || op == OP_FRECT ||
                             op == OP_CIRC || op == OP_FCIRC;
  assign status.is_erase   = op == OP_ERASE;
  assign status.is_stamp   = op == OP_STAMP;
  assign status.is_read    = op == OP_READ;
  assign status.is_clear   = op == OP_CLEAR;

  // line step
  logic signed [CW+1:0] e2;
  assign e2 = err <<< 1;

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        op <= opcode;
        color <= (opcode == OP_ERASE) ? 32'd0 : draw_color;
        clr_addr <= '0;
        oct <= '0;
        edge_sel <= '0;
        ldx <= (start_x > end_x) ? CW'(start_x - end_x) : CW'(end_x - start_x);
        ldy <= (start_y > end_y) ? CW'(start_y - end_y) : CW'(end_y - start_y);
        lsx <= !(start_x < end_x);
        lsy <= !(start_y < end_y);
        if (opcode == OP_CIRC) err <= '0;
        else
          err <= (CW+2)'($signed({1'b0, (start_x > end_x) ? start_x - end_x
                                                            : end_x - start_x}))
               - (CW+2)'($signed({1'b0, (start_y > end_y) ? start_y - end_y
                                                            : end_y - start_y}));
        if (opcode == OP_RECT || opcode == OP_FRECT) begin
          xa <= CW'((start_x < end_x) ? start_x : end_x);
          xb <= CW'((start_x < end_x) ? end_x : start_x);
          ya <= CW'((start_y < end_y) ? start_y : end_y);
          yb <= CW'((start_y < end_y) ? end_y : start_y);
          px <= CW'((start_x < end_x) ? start_x : end_x);
          py <= CW'((start_y < end_y) ? start_y : end_y);
        end else begin
          xa <= CW'(start_x); ya <= CW'(start_y);
          xb <= CW'(end_x);   yb <= CW'(end_y);
          px <= CW'(start_x); py <= CW'(start_y);
        end
        ccx <= CW'((7'(start_x) + 7'(end_x)) >> 1);
        ccy <= CW'((7'(start_y) + 7'(end_y)) >> 1);
        begin
          logic [5:0] rx, ry, rr;
          rx = ((start_x > end_x) ? start_x - end_x : end_x - start_x) >> 1;
          ry = ((start_y > end_y) ? start_y - end_y : end_y - start_y) >> 1;
          rr = (rx > ry) ? rx : ry;
          cr <= CW'(rr);
          if (opcode == OP_FCIRC) begin
            cu <= -CW'(rr); cv <= -CW'(rr);
          end else begin
            cu <= CW'(rr); cv <= '0;
          end
        end
      end
      CMD_STAMP_INIT: begin
        sxv <= ptx - CW'(hb);
        syv <= pty - CW'(hb);
      end
      CMD_STAMP_STEP: begin
        if (sxv == ptx + CW'(hb)) begin
          sxv <= ptx - CW'(hb);
          syv <= syv + 1;
        end else begin
          sxv <= sxv + 1;
        end
      end
      CMD_SHAPE_STEP: begin
        case (op)
          OP_LINE: begin
            if (e2 > -(CW+2)'(ldy) && e2 < (CW+2)'(ldx))
              err <= err - (CW+2)'(ldy) + (CW+2)'(ldx);
            else if (e2 > -(CW+2)'(ldy))
              err <= err - (CW+2)'(ldy);
            else if (e2 < (CW+2)'(ldx))
              err <= err + (CW+2)'(ldx);
            if (e2 > -(CW+2)'(ldy)) px <= lsx ? px - 1 : px + 1;
            if (e2 < (CW+2)'(ldx)) py <= lsy ? py - 1 : py + 1;
          end
          OP_FRECT: begin
            if (px == xb) begin px <= xa; py <= py + 1; end
            else px <= px + 1;
          end
          OP_RECT: begin
            // phases: top row, bottom row, left col, right col interleaved
            unique case (edge_sel)
              2'd0: begin edge_sel <= 2'd1; py <= yb; end
              2'd1: begin
                if (px == xb) begin
                  edge_sel <= 2'd2; px <= xa; py <= ya + 1;
                end else begin
                  edge_sel <= 2'd0; px <= px + 1; py <= ya;
                end
              end
              2'd2: begin edge_sel <= 2'd3; px <= xb; end
              default: begin edge_sel <= 2'd2; px <= xa; py <= py + 1; end
            endcase
          end
          OP_CIRC: begin
            oct <= oct + 1;
            if (oct == 3'd7) begin
              cu <= nu; cv <= nv; err <= nerr;
            end
          end
          OP_FCIRC: begin
            if (cu == cr) begin cu <= -cr; cv <= cv + 1; end
            else cu <= cu + 1;
          end
          default: ;
        endcase
      end
      CMD_CLEAR_INIT: clr_addr <= '0;
      CMD_CLEAR_STEP: clr_addr <= clr_addr + 1;
      CMD_READ_ADDR: read_ok <= ins(xa, ya, gsi);
      CMD_READ_TAKE: begin
        read_color <= read_ok ? ram_rdata : 32'd0;
        in_grid <= read_ok;
      end
      default: begin
        if (cmd == CMD_NONE && op != OP_READ) begin
          read_color <= 32'd0; in_grid <= 1'b0;
        end
      end
    endcase
    if (cmd == CMD_LOAD) begin
      read_color <= 32'd0; in_grid <= 1'b0;
    end
  end

  // store port
  always_comb begin
    ram_we = 1'b0;
    ram_addr = MW'({ya[AW-1:0]} * MAX_GRID) | MW'(xa[AW-1:0]);
    ram_wdata = color;
    if (cmd == CMD_CLEAR_STEP) begin
      ram_we = 1'b1; ram_addr = clr_addr; ram_wdata = 32'd0;
    end else if (cmd == CMD_STAMP_STEP) begin
      ram_we = ins(sxv, syv, gsi);
      ram_addr = MW'(MW'(syv[AW-1:0]) * MW'(MAX_GRID)) + MW'(sxv[AW-1:0]);
    end else begin
      ram_addr = MW'(MW'(ya[AW-1:0]) * MW'(MAX_GRID)) + MW'(xa[AW-1:0]);
    end
  end

  bsr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );
endmodule
`default_nettype wire

@@ hdl/bsr_ctrl.sv @@
// command sequencer for the rasterizer
`timescale 1ns / 1ps
`default_nettype none
module bsr_ctrl
  import bsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire status_t status,
  output cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_RESET, S_CLR, S_IDLE, S_DECODE, S_PT, S_STAMP_INIT, S_STAMP, S_NEXT,
    S_READ0, S_READ1, S_READ2, S_CLEAR, S_DONE
  } state_t;
  state_t state;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    cmd = CMD_NONE;
    unique case (state)
      S_RESET:      cmd = CMD_CLEAR_INIT;
      S_CLR:        cmd = CMD_CLEAR_STEP;
      S_IDLE:       if (in_valid && !in_stall) cmd = CMD_LOAD;
      S_STAMP_INIT: cmd = CMD_STAMP_INIT;
      S_STAMP:      cmd = CMD_STAMP_STEP;
      S_NEXT:       cmd = CMD_SHAPE_STEP;
      S_READ0:      cmd = CMD_READ_ADDR;
      S_READ2:      cmd = CMD_READ_TAKE;
      S_CLEAR:      cmd = CMD_CLEAR_STEP;
      default:      cmd = CMD_NONE;
    endcase
  end

  // state and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RESET;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_RESET: state <= S_CLR;
        S_CLR:   if (status.clear_last) state <= S_IDLE;
        S_IDLE:  if (in_valid && !in_stall) state <= S_DECODE;
        S_DECODE: begin
          if (status.is_read) state <= S_READ0;
          else if (status.is_clear) state <= S_CLEAR;
          else if (status.is_erase) state <= S_STAMP_INIT;
          else if (status.is_stamp || status.is_shape) state <= S_PT;
          else state <= S_DONE;
        end
        S_PT: begin
          if (status.point_ok) state <= S_STAMP_INIT;
          else if (status.is_shape && !status.shape_last) state <= S_NEXT;
          else state <= S_DONE;
        end
        S_STAMP_INIT: state <= S_STAMP;
        S_STAMP: begin
          if (status.stamp_last) begin
            if (status.is_shape && !status.shape_last) state <= S_NEXT;
            else state <= S_DONE;
          end
        end
        S_NEXT:  state <= S_PT;
        S_READ0: state <= S_READ1;
        S_READ1: state <= S_READ2;
        S_READ2: state <= S_DONE;
        S_CLEAR: if (status.clear_last) state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ bench/bsr_checker.sv @@
// checker: predicts rasterizer results from accepted commands and compares them
`timescale 1ns / 1ps
`default_nettype none
module bsr_checker
  import bsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [3:0]  opcode,
  input  wire logic [5:0]  start_x,
  input  wire logic [5:0]  start_y,
  input  wire logic [5:0]  end_x,
  input  wire logic [5:0]  end_y,
  input  wire logic [31:0] draw_color,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] read_color,
  input  wire logic        in_grid,
  output int               fail_count,
  output int               pending_reads
);
  localparam int GRID_MAX  = MAX_GRID_DEF;
  localparam int BRUSH_MAX = MAX_BRUSH_DEF;

  typedef struct {
    logic [31:0] color;
    logic        hit;
  } pixel_reply_t;

  logic [31:0]  canvas [GRID_MAX*GRID_MAX];
  logic [6:0]   grid_reg;
  logic [3:0]   brush_reg;
  pixel_reply_t reply_q [$];

  assign pending_reads = reply_q.size();

  function automatic int side();
    return (grid_reg > GRID_MAX) ? GRID_MAX : int'(grid_reg);
  endfunction

  function automatic bit on_canvas(int x, int y);
    int g;
    g = side();
    return x >= 0 && x < g && y >= 0 && y < g;
  endfunction

  // brush square, clipped to the grid
  task automatic paint_square(int cx, int cy, logic [31:0] c);
    int h;
    h = ((brush_reg > BRUSH_MAX) ? BRUSH_MAX : int'(brush_reg)) / 2;
    for (int y = cy - h; y <= cy + h; y++)
      for (int x = cx - h; x <= cx + h; x++)
        if (on_canvas(x, y)) canvas[y*GRID_MAX + x] = c;
  endtask

  task automatic dab(int x, int y, logic [31:0] c);
    if (on_canvas(x, y)) paint_square(x, y, c);
  endtask

  task automatic trace_line(int x1, int y1, int x2, int y2, logic [31:0] c);
    int dx, dy, sx, sy, err, e2;
    dx = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy = (y1 > y2) ? y1 - y2 : y2 - y1;
    sx = (x1 < x2) ? 1 : -1;
    sy = (y1 < y2) ? 1 : -1;
    err = dx - dy;
    forever begin
      dab(x1, y1, c);
      if (x1 == x2 && y1 == y2) break;
      e2 = 2 * err;
      if (e2 > -dy) begin err -= dy; x1 += sx; end
      if (e2 < dx) begin err += dx; y1 += sy; end
    end
  endtask

  task automatic trace_box(int x1, int y1, int x2, int y2, bit fill, logic [31:0] c);
    int t;
    if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
    if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
    if (fill) begin
      for (int y = y1; y <= y2; y++)
        for (int x = x1; x <= x2; x++) dab(x, y, c);
    end else begin
      for (int x = x1; x <= x2; x++) begin dab(x, y1, c); dab(x, y2, c); end
      for (int y = y1 + 1; y < y2; y++) begin dab(x1, y, c); dab(x2, y, c); end
    end
  endtask

  task automatic trace_ring(int x1, int y1, int x2, int y2, bit fill, logic [31:0] c);
    int cx, cy, rx, ry, r, x, y, err;
    cx = (x1 + x2) / 2;
    cy = (y1 + y2) / 2;
    rx = ((x1 > x2) ? x1 - x2 : x2 - x1) / 2;
    ry = ((y1 > y2) ? y1 - y2 : y2 - y1) / 2;
    r = (rx > ry) ? rx : ry;
    if (fill) begin
      for (int j = -r; j <= r; j++)
        for (int i = -r; i <= r; i++)
          if (i*i + j*j <= r*r) dab(cx + i, cy + j, c);
    end else begin
      x = r; y = 0; err = 0;
      while (x >= y) begin
        dab(cx + x, cy + y, c); dab(cx + y, cy + x, c);
        dab(cx - y, cy + x, c); dab(cx - x, cy + y, c);
        dab(cx - x, cy - y, c); dab(cx - y, cy - x, c);
        dab(cx + y, cy - x, c); dab(cx + x, cy - y, c);
        if (err <= 0) begin y += 1; err += 2*y + 1; end
        if (err > 0) begin x -= 1; err -= 2*x + 1; end
      end
    end
  endtask

  task automatic run_command();
    pixel_reply_t r;
    int sx, sy, ex, ey;
    sx = start_x; sy = start_y; ex = end_x; ey = end_y;
    r.color = '0;
    r.hit = 1'b0;
    case (opcode)
      OP_STAMP: dab(sx, sy, draw_color);
      OP_ERASE: paint_square(sx, sy, '0);
      OP_LINE:  trace_line(sx, sy, ex, ey, draw_color);
      OP_RECT:  trace_box(sx, sy, ex, ey, 1'b0, draw_color);
      OP_FRECT: trace_box(sx, sy, ex, ey, 1'b1, draw_color);
      OP_CIRC:  trace_ring(sx, sy, ex, ey, 1'b0, draw_color);
      OP_FCIRC: trace_ring(sx, sy, ex, ey, 1'b1, draw_color);
      OP_READ: begin
        if (on_canvas(sx, sy)) begin
          r.color = canvas[sy*GRID_MAX + sx];
          r.hit = 1'b1;
        end
      end
      OP_CLEAR: foreach (canvas[i]) canvas[i] = '0;
      default: ;
    endcase
    reply_q.push_back(r);
  endtask

  // watch config writes, commands and results
  always @(posedge clk) begin
    pixel_reply_t want;
    if (rst) begin
      foreach (canvas[i]) canvas[i] = '0;
      grid_reg = 7'd32;
      brush_reg = 4'd1;
      reply_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_GRID) grid_reg = pwdata[6:0];
        else if (paddr == ADDR_BRUSH) brush_reg = pwdata[3:0];
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: read_color %h in_grid %b", read_color, in_grid);
        end else begin
          want = reply_q.pop_front();
          if (want.color !== read_color || want.hit !== in_grid) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: read_color exp %h got %h, in_grid exp %b got %b",
                       want.color, read_color, want.hit, in_grid);
          end
        end
      end
      if (in_valid && !in_stall) run_command();
    end
  end
endmodule
`default_nettype wire

@@ bench/tb_brush_shape_rasterizer.sv @@
// testbench top: clock, reset, stimulus and verdict for the brush shape rasterizer
`timescale 1ns / 1ps
`default_nettype none
module tb_brush_shape_rasterizer
  import bsr_pkg::*;
();
  localparam int CYCLE_LIMIT = 20_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  opcode = '0;
  logic [5:0]  start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [31:0] draw_color = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_color;
  logic        in_grid;
  int          fail_count, pending_reads;
  int          cycles = 0;
  bit          steady = 1'b0;
  int          span = 6;
  int          last_x = 0, last_y = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  brush_shape_rasterizer u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .opcode, .start_x, .start_y, .end_x, .end_y, .draw_color,
    .out_valid, .out_stall, .read_color, .in_grid
  );

  bsr_checker u_chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .opcode, .start_x, .start_y, .end_x, .end_y, .draw_color,
    .out_valid, .out_stall, .read_color, .in_grid, .fail_count, .pending_reads
  );

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** brush_shape_rasterizer: FAILED **");
      $finish;
    end
  end

  // result side stall
  always @(negedge clk)
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 36);

  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drain results, settle, then retune grid and brush
  task automatic retune(logic [6:0] grid, logic [3:0] brush);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reads != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    reg_write(ADDR_GRID, {$urandom} & 32'hFFFF_FF80 | grid);
    reg_write(ADDR_BRUSH, {$urandom} & 32'hFFFF_FFF0 | brush);
  endtask

  // one command beat with random idle ahead of it
  task automatic send_cmd(logic [3:0] op, int sx, int sy, int ex, int ey, logic [31:0] c);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    opcode <= op; start_x <= 6'(sx); start_y <= 6'(sy); end_x <= 6'(ex); end_y <= 6'(ey);
    draw_color <= c; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic int near(int v);
    int n;
    n = v + $urandom_range(2*span) - span;
    return n < 0 ? 0 : (n > 63 ? 63 : n);
  endfunction

  // mostly small shapes near recent points, and reads near recently drawn points
  task automatic random_cmd();
    int pick, sx, sy, ex, ey;
    logic [3:0] op;
    pick = $urandom_range(99);
    if ($urandom_range(3) == 0) begin
      sx = $urandom_range(63); sy = $urandom_range(63);
    end else begin
      sx = near(last_x); sy = near(last_y);
    end
    ex = near(sx); ey = near(sy);
    if (pick < 30) op = OP_READ;
    else if (pick < 40) op = OP_STAMP;
    else if (pick < 47) op = OP_ERASE;
    else if (pick < 59) op = OP_LINE;
    else if (pick < 67) op = OP_RECT;
    else if (pick < 74) op = OP_FRECT;
    else if (pick < 83) op = OP_CIRC;
    else if (pick < 90) op = OP_FCIRC;
    else if (pick < 92) op = OP_CLEAR;
    else if (pick < 95) op = 4'($urandom_range(15, 9));
    else begin
      op = 4'($urandom_range(15));
      ex = $urandom_range(63); ey = $urandom_range(63);
    end
    if (op != OP_READ) begin last_x = sx; last_y = sy; end
    send_cmd(op, sx, sy, ex, ey, $urandom);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed: every operation at the default grid
    send_cmd(OP_READ, 0, 0, 0, 0, '1);
    send_cmd(OP_STAMP, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_cmd(OP_STAMP, 31, 31, 0, 0, 32'h1234_5678);
    send_cmd(OP_STAMP, 32, 0, 0, 0, 32'hDEAD_BEEF);
    send_cmd(OP_READ, 0, 0, 0, 0, '0);
    send_cmd(OP_READ, 31, 31, 0, 0, '0);
    send_cmd(OP_READ, 63, 63, 0, 0, '0);
    send_cmd(OP_LINE, 0, 31, 31, 0, 32'hAAAA_5555);
    send_cmd(OP_READ, 16, 15, 0, 0, '0);
    send_cmd(OP_RECT, 20, 20, 2, 2, 32'h5555_AAAA);
    send_cmd(OP_READ, 2, 10, 0, 0, '0);
    send_cmd(OP_FRECT, 10, 12, 4, 6, 32'h0F0F_F0F0);
    send_cmd(OP_READ, 7, 9, 0, 0, '0);
    send_cmd(OP_CIRC, 0, 0, 31, 31, 32'hC0C0_C0C0);
    send_cmd(OP_FCIRC, 20, 30, 28, 22, 32'h0303_0303);
    send_cmd(OP_READ, 24, 26, 0, 0, '0);
    send_cmd(OP_ERASE, 24, 26, 0, 0, '1);
    send_cmd(OP_READ, 24, 26, 0, 0, '0);
    send_cmd(4'd15, 63, 63, 63, 63, '1);
    send_cmd(OP_CLEAR, 0, 0, 0, 0, '1);
    send_cmd(OP_READ, 31, 31, 0, 0, '0);

    // brush extremes, erase centered outside the grid, zero grid
    retune(7'd64, 4'd15);
    send_cmd(OP_STAMP, 63, 63, 0, 0, 32'h8000_0001);
    send_cmd(OP_ERASE, 0, 0, 0, 0, '0);
    send_cmd(OP_READ, 60, 60, 0, 0, '0);
    retune(7'd60, 4'd15);
    send_cmd(OP_ERASE, 63, 63, 0, 0, '0);
    retune(7'd64, 4'd0);
    send_cmd(OP_READ, 57, 57, 0, 0, '0);
    send_cmd(OP_READ, 62, 62, 0, 0, '0);
    retune(7'd0, 4'd1);
    send_cmd(OP_STAMP, 0, 0, 0, 0, '1);
    send_cmd(OP_READ, 0, 0, 0, 0, '0);
    retune(7'd127, 4'd3);
    send_cmd(OP_READ, 63, 63, 0, 0, '0);

    // random phases over a spread of settings
    for (int ph = 0; ph < 10; ph++) begin
      logic [6:0] g;
      logic [3:0] b;
      int n;
      case (ph)
        0: begin g = 7'd64;  b = 4'd1;  end
        1: begin g = 7'd1;   b = 4'd2;  end
        2: begin g = 7'd16;  b = 4'd3;  end
        3: begin g = 7'd0;   b = 4'd1;  end
        4: begin g = 7'd127; b = 4'd0;  end
        5: begin g = 7'd64;  b = 4'd15; end
        6: begin g = 7'd40;  b = 4'd5;  end
        7: begin g = 7'd8;   b = 4'd4;  end
        8: begin g = 7'd64;  b = 4'd2;  end
        default: begin g = 7'($urandom_range(1, 64)); b = 4'($urandom_range(1, 3)); end
      endcase
      retune(g, b);
      span = (b > 6) ? 1 : 6;
      n = (b > 6) ? 60 : 240;
      steady = (ph == 8);
      for (int i = 0; i < n; i++) random_cmd();
      steady = 1'b0;
    end

    // a few large shapes with a thin brush
    retune(7'd64, 4'd1);
    send_cmd(OP_FCIRC, 0, 0, 63, 63, $urandom);
    send_cmd(OP_LINE, 63, 0, 0, 63, $urandom);
    send_cmd(OP_RECT, 63, 63, 0, 0, $urandom);
    for (int i = 0; i < 40; i++)
      send_cmd(OP_READ, $urandom_range(63), $urandom_range(63), 0, 0, $urandom);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reads != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("** brush_shape_rasterizer: PASSED **");
    end else begin
      $display("** brush_shape_rasterizer: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
hdl/bsr_pkg.sv
hdl/bsr_ram.sv
hdl/bsr_datapath.sv
hdl/bsr_ctrl.sv
hdl/brush_shape_rasterizer.sv
bench/bsr_checker.sv
bench/tb_brush_shape_rasterizer.sv
